// ===== rtl/core/utf8sd_pkg.sv =====
// Shared constants, byte classes and automaton table for the UTF-8 stream decoder.
`default_nettype none

package utf8sd_pkg;

    localparam int PENDING_DEPTH = 4;
    localparam int BYTE_W        = 8;
    localparam int CP_W          = 21;
    localparam int AST_W         = 4;
    localparam int CLS_W         = 4;

    localparam logic [CP_W-1:0] ESC_BASE = 21'h00DC00;

    // Function codes carried on the input tuser
    localparam logic FUNC_PUSH   = 1'b0;
    localparam logic FUNC_FINISH = 1'b1;

    // Automaton states
    localparam logic [AST_W-1:0] A_ACC = 4'd0;
    localparam logic [AST_W-1:0] A_REJ = 4'd1;
    localparam logic [AST_W-1:0] A_T1  = 4'd2;
    localparam logic [AST_W-1:0] A_T2  = 4'd3;
    localparam logic [AST_W-1:0] A_T3  = 4'd4;
    localparam logic [AST_W-1:0] A_T2A = 4'd5;
    localparam logic [AST_W-1:0] A_T2B = 4'd6;
    localparam logic [AST_W-1:0] A_T3A = 4'd7;
    localparam logic [AST_W-1:0] A_T3B = 4'd8;

    // Byte classes
    localparam logic [CLS_W-1:0] C_ASCII    = 4'd0;
    localparam logic [CLS_W-1:0] C_CONT_LO  = 4'd1;   // 80..8F
    localparam logic [CLS_W-1:0] C_CONT_MID = 4'd2;   // 90..9F
    localparam logic [CLS_W-1:0] C_CONT_HI  = 4'd3;   // A0..BF
    localparam logic [CLS_W-1:0] C_INVALID  = 4'd4;
    localparam logic [CLS_W-1:0] C_LEAD2    = 4'd5;
    localparam logic [CLS_W-1:0] C_E0       = 4'd6;
    localparam logic [CLS_W-1:0] C_LEAD3    = 4'd7;
    localparam logic [CLS_W-1:0] C_ED       = 4'd8;
    localparam logic [CLS_W-1:0] C_F0       = 4'd9;
    localparam logic [CLS_W-1:0] C_LEAD4    = 4'd10;
    localparam logic [CLS_W-1:0] C_F4       = 4'd11;

    function automatic logic [CLS_W-1:0] byte_class(input logic [BYTE_W-1:0] b);
        logic [CLS_W-1:0] cls;
        case (b) inside
            [8'h00:8'h7F]: cls = C_ASCII;
            [8'h80:8'h8F]: cls = C_CONT_LO;
            [8'h90:8'h9F]: cls = C_CONT_MID;
            [8'hA0:8'hBF]: cls = C_CONT_HI;
            [8'hC0:8'hC1]: cls = C_INVALID;
            [8'hC2:8'hDF]: cls = C_LEAD2;
            8'hE0:         cls = C_E0;
            8'hED:         cls = C_ED;
            [8'hE1:8'hEF]: cls = C_LEAD3;
            8'hF0:         cls = C_F0;
            [8'hF1:8'hF3]: cls = C_LEAD4;
            8'hF4:         cls = C_F4;
            default:       cls = C_INVALID;
        endcase
        return cls;
    endfunction

    function automatic logic [BYTE_W-1:0] first_mask(input logic [CLS_W-1:0] cls);
        logic [BYTE_W-1:0] m;
        case (cls) inside
            C_ASCII:                m = 8'h7F;
            C_LEAD2:                m = 8'h1F;
            C_E0, C_LEAD3, C_ED:    m = 8'h0F;
            C_F0, C_LEAD4, C_F4:    m = 8'h07;
            default:                m = 8'h00;
        endcase
        return m;
    endfunction

    function automatic logic [AST_W-1:0] next_state(input logic [AST_W-1:0] st,
                                                    input logic [CLS_W-1:0] cls);
        logic [AST_W-1:0] ns;
        ns = A_REJ;
        case (st)
            A_ACC: begin
                case (cls)
                    C_ASCII:  ns = A_ACC;
                    C_LEAD2:  ns = A_T1;
                    C_E0:     ns = A_T2A;
                    C_LEAD3:  ns = A_T2;
                    C_ED:     ns = A_T2B;
                    C_F0:     ns = A_T3A;
                    C_LEAD4:  ns = A_T3;
                    C_F4:     ns = A_T3B;
                    default:  ns = A_REJ;
                endcase
            end
            A_T1:  if (cls inside {C_CONT_LO, C_CONT_MID, C_CONT_HI}) ns = A_ACC;
            A_T2:  if (cls inside {C_CONT_LO, C_CONT_MID, C_CONT_HI}) ns = A_T1;
            A_T3:  if (cls inside {C_CONT_LO, C_CONT_MID, C_CONT_HI}) ns = A_T2;
            A_T2A: if (cls == C_CONT_HI) ns = A_T1;
            A_T2B: if (cls inside {C_CONT_LO, C_CONT_MID}) ns = A_T1;
            A_T3A: if (cls inside {C_CONT_MID, C_CONT_HI}) ns = A_T2;
            A_T3B: if (cls == C_CONT_LO) ns = A_T2;
            default: ns = A_REJ;
        endcase
        return ns;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/utf8_stream_decoder_escape_top.sv =====
// Top level of the streaming UTF-8 decoder with escapes for undecodable bytes.
//
// Input channel (s_*): one transaction per byte. s_tuser[0] = 0 pushes s_tdata
// as the next raw byte; s_tuser[0] = 1 finishes the stream, flushing every
// pending byte as an escape (0xDC00 + byte) and emptying the store.
// Output channel (m_*): m_tdata[20:0] is a code point, m_tuser[0] marks an
// escape, m_tlast marks the final result caused by one input transaction. An
// input that only extends an unfinished sequence, or a finish with nothing
// pending, yields no result.
// Timing: one shared automaton step looks at one pending byte per cycle while no
// result waits for room. A push is accepted in idle, then the scan state steps
// through the pending bytes (at most 4 per result, rescanning from the oldest
// byte after each result), and a closing state passes on the last result when
// the run yields results; a plain ASCII byte goes from the scan state through the
// hold register and the closing state to the output register. A push that only
// extends a sequence returns to idle once its bytes are scanned. A finish sends
// one escape per pending byte from the flush state. s_tready is high only when idle.
// Results are buffered in a hold register and the output register; a stalled
// m_tready holds the sequencer once a result has nowhere to go. Nothing is lost.
// Reset (aresetn low, synchronous) empties the store and drops any result.
`default_nettype none

module utf8_stream_decoder_escape_top #(
    parameter int PENDING_DEPTH = utf8sd_pkg::PENDING_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  s_tuser,   // [0] func
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [20:0] code_point, [23:21] zero
    output logic [0:0]       m_tuser,   // [0] is_escape
    output logic             m_tlast
);

    localparam int PTR_W = $clog2(PENDING_DEPTH);
    localparam int CNT_W = $clog2(PENDING_DEPTH + 1);
    localparam int BW    = utf8sd_pkg::BYTE_W;
    localparam int CW    = utf8sd_pkg::CP_W;
    localparam int AW    = utf8sd_pkg::AST_W;

    // sequencer states
    localparam logic [1:0] FSM_IDLE  = 2'd0;
    localparam logic [1:0] FSM_SCAN  = 2'd1;
    localparam logic [1:0] FSM_FLUSH = 2'd2;
    localparam logic [1:0] FSM_LAST  = 2'd3;

    logic [1:0]       fsm_reg, fsm_next;

    // pending byte store, circular from head_reg
    logic [BW-1:0]    pend_reg [PENDING_DEPTH];
    logic [PTR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;

    // scan position and automaton state
    logic [PTR_W-1:0] idx_reg, idx_next;
    logic [AW-1:0]    ast_reg, ast_next;
    logic [CW-1:0]    acc_reg, acc_next;
    logic [BW-1:0]    first_reg, first_next;

    // one result held until we know whether it closes the run
    logic             hold_valid_reg, hold_valid_next;
    logic [CW-1:0]    hold_cp_reg, hold_cp_next;
    logic             hold_esc_reg, hold_esc_next;

    // output register
    logic             m_valid_reg, m_valid_next;
    logic [CW-1:0]    m_cp_reg, m_cp_next;
    logic             m_esc_reg, m_esc_next;
    logic             m_last_reg, m_last_next;

    logic [PTR_W-1:0] rd_addr;
    logic [BW-1:0]    rd_byte;
    logic [AW-1:0]    step_st;
    logic [CW-1:0]    step_acc;
    logic [BW-1:0]    esc_byte;
    logic [CW-1:0]    esc_cp;
    logic [CNT_W-1:0] idx_inc;
    logic [CNT_W-1:0] drop;
    logic             idx_last;
    logic             out_free;
    logic             s_fire;
    logic             res_rej;
    logic             res_acc;

    assign rd_addr  = head_reg + idx_reg;
    assign rd_byte  = pend_reg[rd_addr];
    assign wr_addr  = head_reg + cnt_reg[PTR_W-1:0];
    assign idx_inc  = CNT_W'(idx_reg) + CNT_W'(1);
    assign idx_last = (idx_inc == cnt_reg);
    // oldest byte: the one under scan at position zero, else the captured copy
    assign esc_byte = (idx_reg == '0) ? rd_byte : first_reg;
    assign esc_cp   = utf8sd_pkg::ESC_BASE + CW'(esc_byte);
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (fsm_reg == FSM_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign res_rej  = (step_st == utf8sd_pkg::A_REJ);
    assign res_acc  = (step_st == utf8sd_pkg::A_ACC);
    assign drop     = res_rej ? CNT_W'(1) : idx_inc;

    utf8sd_step u_step (
        .byte_i (rd_byte),
        .st_i   (ast_reg),
        .acc_i  (acc_reg),
        .st_o   (step_st),
        .acc_o  (step_acc)
    );

    always_comb begin
        fsm_next        = fsm_reg;
        head_next       = head_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        ast_next        = ast_reg;
        acc_next        = acc_reg;
        first_next      = first_reg;
        hold_valid_next = hold_valid_reg;
        hold_cp_next    = hold_cp_reg;
        hold_esc_next   = hold_esc_reg;
        m_valid_next    = m_valid_reg;
        m_cp_next       = m_cp_reg;
        m_esc_next      = m_esc_reg;
        m_last_next     = m_last_reg;
        wr_en           = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (fsm_reg)
            FSM_IDLE: begin
                if (s_fire) begin
                    idx_next = '0;
                    ast_next = utf8sd_pkg::A_ACC;
                    if (s_tuser[0] == utf8sd_pkg::FUNC_PUSH) begin
                        wr_en    = 1'b1;
                        cnt_next = cnt_reg + CNT_W'(1);
                        fsm_next = FSM_SCAN;
                    end else if (cnt_reg != '0) begin
                        fsm_next = FSM_FLUSH;
                    end
                end
            end
            FSM_FLUSH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_cp_next    = utf8sd_pkg::ESC_BASE + CW'(rd_byte);
                    m_esc_next   = 1'b1;
                    m_last_next  = idx_last;
                    idx_next     = idx_reg + PTR_W'(1);
                    if (idx_last) begin
                        cnt_next = '0;
                        fsm_next = FSM_IDLE;
                    end
                end
            end
            FSM_SCAN: begin
                if (res_rej || res_acc) begin
                    // a new result may only land once the held one can move on
                    if (!hold_valid_reg || out_free) begin
                        if (hold_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_cp_next    = hold_cp_reg;
                            m_esc_next   = hold_esc_reg;
                            m_last_next  = 1'b0;
                        end
                        hold_valid_next = 1'b1;
                        hold_cp_next    = res_rej ? esc_cp : step_acc;
                        hold_esc_next   = res_rej;
                        head_next       = head_reg + drop[PTR_W-1:0];
                        cnt_next        = cnt_reg - drop;
                        idx_next        = '0;
                        ast_next        = utf8sd_pkg::A_ACC;
                        if (cnt_reg == drop) begin
                            fsm_next = FSM_LAST;
                        end
                    end
                end else if (idx_last) begin
                    // unfinished tail stays pending
                    fsm_next = hold_valid_reg ? FSM_LAST : FSM_IDLE;
                end else begin
                    if (idx_reg == '0) begin
                        first_next = rd_byte;
                    end
                    idx_next = idx_reg + PTR_W'(1);
                    ast_next = step_st;
                    acc_next = step_acc;
                end
            end
            FSM_LAST: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_cp_next       = hold_cp_reg;
                    m_esc_next      = hold_esc_reg;
                    m_last_next     = 1'b1;
                    hold_valid_next = 1'b0;
                    fsm_next        = FSM_IDLE;
                end
            end
            default: begin
                fsm_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg        <= FSM_IDLE;
            cnt_reg        <= '0;
            head_reg       <= '0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            fsm_reg        <= fsm_next;
            cnt_reg        <= cnt_next;
            head_reg       <= head_next;
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        ast_reg      <= ast_next;
        acc_reg      <= acc_next;
        first_reg    <= first_next;
        hold_cp_reg  <= hold_cp_next;
        hold_esc_reg <= hold_esc_next;
        m_cp_reg     <= m_cp_next;
        m_esc_reg    <= m_esc_next;
        m_last_reg   <= m_last_next;
        if (wr_en) begin
            pend_reg[wr_addr] <= s_tdata;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {3'b000, m_cp_reg};
    assign m_tuser[0] = m_esc_reg;
    assign m_tlast    = m_last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/utf8sd_step.sv =====
// One automaton step: classify a byte, advance the state, fold bits into the code point.
`default_nettype none

module utf8sd_step (
    input  wire logic [utf8sd_pkg::BYTE_W-1:0] byte_i,
    input  wire logic [utf8sd_pkg::AST_W-1:0]  st_i,
    input  wire logic [utf8sd_pkg::CP_W-1:0]   acc_i,
    output logic      [utf8sd_pkg::AST_W-1:0]  st_o,
    output logic      [utf8sd_pkg::CP_W-1:0]   acc_o
);

    logic [utf8sd_pkg::CLS_W-1:0] cls;

    always_comb begin
        cls  = utf8sd_pkg::byte_class(byte_i);
        st_o = utf8sd_pkg::next_state(st_i, cls);
        if (st_i == utf8sd_pkg::A_ACC) begin
            // lead byte starts a fresh value
            acc_o = utf8sd_pkg::CP_W'(byte_i & utf8sd_pkg::first_mask(cls));
        end else begin
            acc_o = {acc_i[utf8sd_pkg::CP_W-7:0], byte_i[5:0]};
        end
    end

endmodule

`default_nettype wire

// ===== dv/tb_utf8_stream_decoder_escape_top.sv =====
// Self-checking testbench for the streaming UTF-8 decoder with byte escapes.
`timescale 1ns / 1ps

module tb_utf8_stream_decoder_escape_top;
    import utf8sd_pkg::*;

    // Cycles with no transaction on either channel before the run is called dead.
    localparam int STALL_LIMIT  = 2000;
    // Settling time after the last expected result; covers a full rescan pass.
    localparam int TAIL_CYCLES  = 32;
    localparam int RANDOM_ITEMS = 295;
    localparam int DIRECTED_N   = 25;

    // One decoded character or escaped byte as seen on the result channel.
    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            esc;
        logic            last;
    } result_t;

    // Directed stimulus row. Where typed is set, n and cp0/esc0, cp1/esc1 give the
    // results outright; otherwise the decoder model supplies them.
    typedef struct packed {
        logic             func;
        logic [7:0]       data;
        logic             typed;
        logic [2:0]       n;
        logic [CP_W-1:0]  cp0;
        logic             esc0;
        logic [CP_W-1:0]  cp1;
        logic             esc1;
    } row_t;

    typedef enum logic [1:0] {SCAN_OPEN, SCAN_HIT, SCAN_MISS} scan_e;

    localparam row_t PLAN [DIRECTED_N] = '{
        // finish on an empty store: nothing comes out
        '{FUNC_FINISH, 8'hA5, 1'b1, 3'd0, 21'h0, 1'b0, 21'h0, 1'b0},
        // ASCII extremes
        '{FUNC_PUSH,   8'h00, 1'b1, 3'd1, 21'h00, 1'b0, 21'h0, 1'b0},
        '{FUNC_PUSH,   8'h7F, 1'b1, 3'd1, 21'h7F, 1'b0, 21'h0, 1'b0},
        // lone continuation, 0xFF and an overlong lead each escape at once
        '{FUNC_PUSH,   8'h80, 1'b1, 3'd1, ESC_BASE + 21'h80, 1'b1, 21'h0, 1'b0},
        '{FUNC_PUSH,   8'hFF, 1'b1, 3'd1, ESC_BASE + 21'hFF, 1'b1, 21'h0, 1'b0},
        '{FUNC_PUSH,   8'hC0, 1'b1, 3'd1, ESC_BASE + 21'hC0, 1'b1, 21'h0, 1'b0},
        // two-byte sequence: the lead alone yields nothing
        '{FUNC_PUSH,   8'hC2, 1'b1, 3'd0, 21'h0, 1'b0, 21'h0, 1'b0},
        '{FUNC_PUSH,   8'hA9, 1'b1, 3'd1, 21'hA9, 1'b0, 21'h0, 1'b0},
        // smallest three-byte value
        '{FUNC_PUSH,   8'hE0, 1'b0, 3'd0, 21'h0, 1'b0, 21'h0, 1'b0},
        '{FUNC_PUSH,   8'hA0, 1'b0, 3'd0, 21'h0, 1'b0, 21'h0, 1'b0},
        '{FUNC_PUSH,   8'h80, 1'b0, 3'd0, 21'h0, 1'b0, 21'h0, 1'b0},
        // overlong three-byte form: lead escapes, then the stray continuation
        '{FUNC_PUSH,   8'hE0, 1'b0, 3'd0, 21'h0, 1'b0, 21'h0, 1'b0},
        '{FUNC_PUSH,   8'h80, 1'b1, 3'd2, ESC_BASE + 21'hE0, 1'b1, ESC_BASE + 21'h80, 1'b1},
        // surrogate
        '{FUNC_PUSH,   8'hED, 1'b0, 3'd0, 21'h0, 1'b0, 21'h0, 1'b0},
        '{FUNC_PUSH,   8'hA0, 1'b1, 3'd2, ESC_BASE + 21'hED, 1'b1, ESC_BASE + 21'hA0, 1'b1},
        // top of the code space
        '{FUNC_PUSH,   8'hF4, 1'b0, 3'd0, 21'h0, 1'b0, 21'h0, 1'b0},
        '{FUNC_PUSH,   8'h8F, 1'b0, 3'd0, 21'h0, 1'b0, 21'h0, 1'b0},
        '{FUNC_PUSH,   8'hBF, 1'b0, 3'd0, 21'h0, 1'b0, 21'h0, 1'b0},
        '{FUNC_PUSH,   8'hBF, 1'b1, 3'd1, 21'h10FFFF, 1'b0, 21'h0, 1'b0},
        // above 0x10FFFF
        '{FUNC_PUSH,   8'hF4, 1'b0, 3'd0, 21'h0, 1'b0, 21'h0, 1'b0},
        '{FUNC_PUSH,   8'h90, 1'b1, 3'd2, ESC_BASE + 21'hF4, 1'b1, ESC_BASE + 21'h90, 1'b1},
        // three pending bytes flushed by a finish
        '{FUNC_PUSH,   8'hF0, 1'b0, 3'd0, 21'h0, 1'b0, 21'h0, 1'b0},
        '{FUNC_PUSH,   8'h90, 1'b0, 3'd0, 21'h0, 1'b0, 21'h0, 1'b0},
        '{FUNC_PUSH,   8'h80, 1'b0, 3'd0, 21'h0, 1'b0, 21'h0, 1'b0},
        '{FUNC_FINISH, 8'h5A, 1'b0, 3'd0, 21'h0, 1'b0, 21'h0, 1'b0}
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic [0:0]  s_tuser  = FUNC_PUSH;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    // Decoder model state: bytes of the unfinished sequence, oldest first.
    logic [7:0] held_bytes [PENDING_DEPTH];
    int         held_count = 0;

    result_t    expected_chars [$];
    int         items_sent  = 0;
    int         mismatches  = 0;
    int         idle_cycles = 0;
    bit         calm        = 1'b0;   // set: neither side idles

    utf8_stream_decoder_escape_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------
    function automatic logic [CLS_W-1:0] classify_byte(input logic [7:0] b);
        if (b < 8'h80)       return C_ASCII;
        else if (b < 8'h90)  return C_CONT_LO;
        else if (b < 8'hA0)  return C_CONT_MID;
        else if (b < 8'hC0)  return C_CONT_HI;
        else if (b < 8'hC2)  return C_INVALID;
        else if (b < 8'hE0)  return C_LEAD2;
        else if (b == 8'hE0) return C_E0;
        else if (b == 8'hED) return C_ED;
        else if (b < 8'hF0)  return C_LEAD3;
        else if (b == 8'hF0) return C_F0;
        else if (b < 8'hF4)  return C_LEAD4;
        else if (b == 8'hF4) return C_F4;
        return C_INVALID;
    endfunction

    // Payload bits of a lead byte; bytes that cannot lead are rejected anyway.
    function automatic logic [CP_W-1:0] lead_bits(input logic [7:0] b);
        if (!b[7])                return {14'd0, b[6:0]};
        else if (b[7:5] == 3'b110) return {16'd0, b[4:0]};
        else if (b[7:4] == 4'hE)   return {17'd0, b[3:0]};
        return {18'd0, b[2:0]};
    endfunction

    function automatic logic [AST_W-1:0] advance_state(input logic [AST_W-1:0] st,
                                                       input logic [CLS_W-1:0] cls);
        logic             lo;
        logic             mid;
        logic             hi;
        logic [AST_W-1:0] ns;
        lo  = (cls == C_CONT_LO);
        mid = (cls == C_CONT_MID);
        hi  = (cls == C_CONT_HI);
        ns  = A_REJ;
        case (st)
            A_ACC: begin
                case (cls)
                    C_ASCII: ns = A_ACC;
                    C_LEAD2: ns = A_T1;
                    C_E0:    ns = A_T2A;
                    C_LEAD3: ns = A_T2;
                    C_ED:    ns = A_T2B;
                    C_F0:    ns = A_T3A;
                    C_LEAD4: ns = A_T3;
                    C_F4:    ns = A_T3B;
                    default: ns = A_REJ;
                endcase
            end
            A_T1:  if (lo || mid || hi) ns = A_ACC;
            A_T2:  if (lo || mid || hi) ns = A_T1;
            A_T3:  if (lo || mid || hi) ns = A_T2;
            A_T2A: if (hi)              ns = A_T1;   // no overlong 3-byte
            A_T2B: if (lo || mid)       ns = A_T1;   // no surrogates
            A_T3A: if (mid || hi)       ns = A_T2;   // no overlong 4-byte
            A_T3B: if (lo)              ns = A_T2;   // nothing past 0x10FFFF
            default: ns = A_REJ;
        endcase
        return ns;
    endfunction

    // Walk the held bytes from the oldest one.
    function automatic scan_e scan_held(output int len, output logic [CP_W-1:0] cp);
        logic [AST_W-1:0] st;
        logic [CP_W-1:0]  acc;
        logic [CLS_W-1:0] cls;
        st  = A_ACC;
        acc = '0;
        len = 0;
        cp  = '0;
        for (int i = 0; i < held_count; i++) begin
            cls = classify_byte(held_bytes[i]);
            if (st == A_ACC)
                acc = lead_bits(held_bytes[i]);
            else
                acc = {acc[CP_W-7:0], held_bytes[i][5:0]};
            st = advance_state(st, cls);
            if (st == A_REJ)
                return SCAN_MISS;
            if (st == A_ACC) begin
                len = i + 1;
                cp  = acc;
                return SCAN_HIT;
            end
        end
        return SCAN_OPEN;
    endfunction

    function automatic void drop_held(input int count);
        if (count >= held_count) begin
            held_count = 0;
        end else begin
            for (int i = 0; i + count < held_count; i++)
                held_bytes[i] = held_bytes[i + count];
            held_count = held_count - count;
        end
    endfunction

    function automatic logic [CP_W-1:0] escape_of(input logic [7:0] b);
        return ESC_BASE + {13'd0, b};
    endfunction

    // Results one input transaction causes; returns how many.
    function automatic int decode_step(input logic func, input logic [7:0] b,
                                       output result_t res [PENDING_DEPTH]);
        int              n;
        int              len;
        logic [CP_W-1:0] cp;
        scan_e           verdict;
        n = 0;
        for (int i = 0; i < PENDING_DEPTH; i++)
            res[i] = '0;
        if (func == FUNC_FINISH) begin
            for (int i = 0; i < held_count; i++) begin
                res[n] = '{escape_of(held_bytes[i]), 1'b1, 1'b0};
                n++;
            end
            held_count = 0;
        end else begin
            // store full: oldest byte makes room as an escape
            if (held_count >= PENDING_DEPTH) begin
                res[n] = '{escape_of(held_bytes[0]), 1'b1, 1'b0};
                n++;
                drop_held(1);
            end
            held_bytes[held_count] = b;
            held_count++;
            while (held_count != 0 && n < PENDING_DEPTH) begin
                verdict = scan_held(len, cp);
                if (verdict == SCAN_OPEN)
                    break;
                if (verdict == SCAN_HIT) begin
                    res[n] = '{cp, 1'b0, 1'b0};
                    drop_held(len);
                end else begin
                    res[n] = '{escape_of(held_bytes[0]), 1'b1, 1'b0};
                    drop_held(1);
                end
                n++;
            end
        end
        if (n > 0)
            res[n-1].last = 1'b1;
        return n;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Offer one item, wait for the transaction, then queue its expected results.
    task automatic offer(input logic func, input logic [7:0] b,
                         input bit typed, input row_t row);
        result_t res [PENDING_DEPTH];
        int      n;
        while (!calm && $urandom_range(99) < 26) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom_range(255));
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        n = decode_step(func, b, res);
        if (typed) begin
            if (row.n > 0)
                expected_chars.push_back('{row.cp0, row.esc0, row.n == 3'd1});
            if (row.n > 1)
                expected_chars.push_back('{row.cp1, row.esc1, 1'b1});
        end else begin
            for (int i = 0; i < n; i++)
                expected_chars.push_back(res[i]);
        end
    endtask

    // Sender holds off until the result channel has caught up.
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_chars.size() != 0)
            @(posedge aclk);
    endtask

    // Encode one scalar value as UTF-8 and push it; with cut set, a multi-byte
    // sequence goes in only as a prefix, followed by a stray byte or a finish.
    task automatic put_scalar(input bit cut);
        logic [CP_W-1:0] cp;
        logic [7:0]      seq [4];
        int              len;
        int              keep;
        case (cut ? $urandom_range(3, 1) : $urandom_range(3))
            0:       cp = 21'($urandom_range(16'h007F));
            1:       cp = 21'($urandom_range(16'h0080, 16'h07FF));
            2: begin
                cp = 21'($urandom_range(16'h0800, 16'hFFFF));
                if (cp >= 21'hD800 && cp <= 21'hDFFF)
                    cp = cp ^ 21'h2000;
            end
            default: cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
        endcase
        // now and then one of the range boundaries
        if ($urandom_range(7) == 0) begin
            case ($urandom_range(9))
                0: cp = 21'h000000;
                1: cp = 21'h00007F;
                2: cp = 21'h000080;
                3: cp = 21'h0007FF;
                4: cp = 21'h000800;
                5: cp = 21'h00D7FF;
                6: cp = 21'h00E000;
                7: cp = 21'h00FFFF;
                8: cp = 21'h010000;
                default: cp = 21'h10FFFF;
            endcase
        end
        if (cp < 21'h80)         len = 1;
        else if (cp < 21'h800)   len = 2;
        else if (cp < 21'h10000) len = 3;
        else                     len = 4;
        case (len)
            1: seq[0] = {1'b0, cp[6:0]};
            2: begin
                seq[0] = {3'b110, cp[10:6]};
                seq[1] = {2'b10, cp[5:0]};
            end
            3: begin
                seq[0] = {4'b1110, cp[15:12]};
                seq[1] = {2'b10, cp[11:6]};
                seq[2] = {2'b10, cp[5:0]};
            end
            default: begin
                seq[0] = {5'b11110, cp[20:18]};
                seq[1] = {2'b10, cp[17:12]};
                seq[2] = {2'b10, cp[11:6]};
                seq[3] = {2'b10, cp[5:0]};
            end
        endcase
        keep = (cut && len > 1) ? $urandom_range(len - 1, 1) : len;
        for (int i = 0; i < keep; i++)
            offer(FUNC_PUSH, seq[i], 1'b0, '0);
        if (cut) begin
            if ($urandom_range(1))
                offer(FUNC_PUSH, 8'($urandom_range(255)), 1'b0, '0);
            else
                offer(FUNC_FINISH, 8'($urandom_range(255)), 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure, scoreboard, watchdog
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 26);
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_chars.size() == 0) begin
                $error("unexpected result transaction: code_point %h", m_tdata);
                mismatches++;
            end else begin
                want = expected_chars.pop_front();
                // pad bits above the code point must stay zero as well
                if (m_tdata !== {3'b000, want.cp}) begin
                    $error("code_point: expected %h, got %h", want.cp, m_tdata);
                    mismatches++;
                end
                if (m_tuser[0] !== want.esc) begin
                    $error("is_escape: expected %b, got %b", want.esc, m_tuser[0]);
                    mismatches++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %b, got %b", want.last, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    // Counts cycles in which neither channel completes a transaction.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $error("no transaction for %0d cycles", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        bit paused;
        int pick;
        paused = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows
        for (int i = 0; i < DIRECTED_N; i++)
            offer(PLAN[i].func, PLAN[i].data, PLAN[i].typed, PLAN[i]);
        hold_until_drained();

        // random part: mostly well-formed text, the rest broken or noise
        while (items_sent < DIRECTED_N + RANDOM_ITEMS) begin
            calm = (items_sent >= 130 && items_sent < 210);
            if (!paused && items_sent >= 240) begin
                hold_until_drained();
                paused = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 60)
                put_scalar(1'b0);
            else if (pick < 75)
                put_scalar(1'b1);
            else if (pick < 90)
                offer(FUNC_PUSH, 8'($urandom_range(255)), 1'b0, '0);
            else
                offer(FUNC_FINISH, 8'($urandom_range(255)), 1'b0, '0);
        end
        calm = 1'b0;

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/utf8sd_pkg.sv
rtl/core/utf8sd_step.sv
rtl/core/utf8_stream_decoder_escape_top.sv
dv/tb_utf8_stream_decoder_escape_top.sv
